// ----- src/gpw_pkg.sv -----
// Package for the glyph pixel writer: field widths, opcodes, register indexes
// and the structs passed between the issue stage, the row builder and the top level.
// No dependencies.
package gpw_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_COLS      = 8;

    localparam int ADDR_W    = 48;
    localparam int DIM_W     = 13;
    localparam int PITCH_W   = 16;
    localparam int POS_W     = 12;
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int FROW_W    = 4;
    localparam int OPCODE_W  = 2;
    localparam int ROW_Y_W   = 13;
    localparam int PROD_W    = ROW_Y_W + PITCH_W;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 312;

    localparam logic [OPCODE_W-1:0] OP_PIXEL = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CHAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd3;

    localparam logic [ADDR_W-1:0]  FRAME_BASE_RST    = '0;
    localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [PITCH_W-1:0] LINE_PITCH_RST    = 16'd2560;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_base;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [PITCH_W-1:0] line_pitch;
    } cfg_t;

    // One row write on its way from the issue stage to the row builder.
    typedef struct packed {
        logic                  valid;
        logic                  pixel;
        logic                  last;
        logic [ROW_Y_W-1:0]    py;
        logic [POS_W-1:0]      x;
        logic [GLYPH_COLS-1:0] mask;
        logic [COLOR_W-1:0]    fg;
        logic [COLOR_W-1:0]    bg;
    } row_cmd_t;

endpackage

// ----- src/gpw_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module gpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/gpw_issue.sv -----
// Command register and row sequencer of the glyph pixel writer: takes input beats,
// steps through glyph rows, drives the font store ports and fills the first stage.
// Depends on gpw_pkg.
module gpw_issue #(
    parameter int MAX_DIM     = gpw_pkg::MAX_DIM_DEF,
    parameter int GLYPH_ROWS  = gpw_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = gpw_pkg::GLYPH_COUNT_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [gpw_pkg::S_TDATA_W-1:0]              s_tdata,
    input  gpw_pkg::cfg_t                              cfg,
    input  logic                                       s1_adv,
    output gpw_pkg::row_cmd_t                          s1,
    output logic                                       ram_wr_en,
    output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0]  ram_wr_addr,
    output logic [gpw_pkg::GLYPH_COLS-1:0]             ram_wr_data,
    output logic                                       ram_rd_en,
    output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0]  ram_rd_addr
);
    import gpw_pkg::*;

    localparam int AW = $clog2(GLYPH_COUNT * GLYPH_ROWS);
    localparam int RW = $clog2(GLYPH_ROWS);
    localparam int GW = $clog2(GLYPH_COUNT);
    localparam int CW = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_ROWS - 1);

    logic                  cmd_valid_reg, cmd_valid_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [POS_W-1:0]      x_reg, y_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [COLOR_W-1:0]    fg_reg, bg_reg;
    logic [FROW_W-1:0]     frow_reg;
    logic [GLYPH_COLS-1:0] fbits_reg;
    row_cmd_t              s1_reg, s1_next;

    logic                  accept, emits, issue, done, on_screen, frow_ok;
    logic [CW-1:0]         w_clip, h_clip;
    logic [ROW_Y_W-1:0]    py;
    logic [GW-1:0]         glyph;
    logic [AW-1:0]         glyph_base;
    logic [GLYPH_COLS-1:0] mask;

    always_comb begin
        w_clip = (CW'(cfg.screen_width) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(cfg.screen_width);
        h_clip = (CW'(cfg.screen_height) > CW'(MAX_DIM)) ? CW'(MAX_DIM)
                                                          : CW'(cfg.screen_height);
        py     = ROW_Y_W'(y_reg) + ROW_Y_W'(row_reg);
        // Codes beyond the glyph count wrap once; codes stay below twice the count.
        glyph  = ({1'b0, code_reg} >= (CODE_W + 1)'(GLYPH_COUNT))
                 ? GW'(code_reg - CODE_W'(GLYPH_COUNT)) : GW'(code_reg);
        glyph_base = AW'(glyph) * AW'(GLYPH_ROWS);
        on_screen  = (CW'(x_reg) < w_clip) && (CW'(y_reg) < h_clip);
        frow_ok    = int'(frow_reg) < GLYPH_ROWS;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            mask[c] = (CW'(py) < h_clip) && (CW'(ROW_Y_W'(x_reg) + ROW_Y_W'(c)) < w_clip);
        end
    end

    always_comb begin
        emits    = cmd_valid_reg && ((op_reg == OP_CHAR) || (op_reg == OP_PIXEL && on_screen));
        issue    = cmd_valid_reg && (!emits || s1_adv);
        done     = issue && !(op_reg == OP_CHAR && row_reg != LAST_ROW);
        s_tready = !cmd_valid_reg || done;
        accept   = s_tvalid && s_tready;

        cmd_valid_next = cmd_valid_reg;
        if (accept) begin
            cmd_valid_next = 1'b1;
        end else if (done) begin
            cmd_valid_next = 1'b0;
        end

        row_next = row_reg;
        if (accept || done) begin
            row_next = '0;
        end else if (issue && op_reg == OP_CHAR) begin
            row_next = row_reg + RW'(1);
        end

        s1_next = s1_reg;
        if (s1_adv) begin
            s1_next.valid = issue && emits;
            s1_next.pixel = (op_reg == OP_PIXEL);
            s1_next.last  = (op_reg == OP_PIXEL) || (row_reg == LAST_ROW);
            s1_next.py    = py;
            s1_next.x     = x_reg;
            s1_next.mask  = (op_reg == OP_PIXEL) ? GLYPH_COLS'(1) : mask;
            s1_next.fg    = fg_reg;
            s1_next.bg    = bg_reg;
        end
    end

    // Font loads write at issue, so every later character read sees them.
    assign ram_wr_en   = issue && (op_reg == OP_LOAD) && frow_ok;
    assign ram_wr_addr = glyph_base + AW'(frow_reg);
    assign ram_wr_data = fbits_reg;
    assign ram_rd_en   = s1_adv;
    assign ram_rd_addr = glyph_base + AW'(row_reg);
    assign s1          = s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            row_reg       <= '0;
            s1_reg        <= '0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            row_reg       <= row_next;
            s1_reg        <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_tdata[1:0];
            x_reg     <= s_tdata[13:2];
            y_reg     <= s_tdata[25:14];
            code_reg  <= s_tdata[33:26];
            fg_reg    <= s_tdata[65:34];
            bg_reg    <= s_tdata[97:66];
            frow_reg  <= s_tdata[101:98];
            fbits_reg <= s_tdata[109:102];
        end
    end

endmodule

// ----- src/gpw_build.sv -----
// Row builder of the glyph pixel writer: multiplies the line by the pitch, expands
// the glyph bits into colours, adds the frame base and holds the output register.
// Depends on gpw_pkg.
module gpw_build (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gpw_pkg::row_cmd_t              s1,
    input  logic [gpw_pkg::GLYPH_COLS-1:0] glyph_bits,
    input  gpw_pkg::cfg_t                  cfg,
    output logic                           s1_adv,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gpw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import gpw_pkg::*;

    logic                  s2_valid_reg, s2_valid_next;
    logic [PROD_W-1:0]     s2_prod_reg;
    logic [POS_W-1:0]      s2_x_reg;
    logic [GLYPH_COLS-1:0] s2_mask_reg;
    logic                  s2_last_reg;
    logic [COLOR_W-1:0]    s2_col_reg [GLYPH_COLS];

    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [GLYPH_COLS-1:0] out_mask_reg;
    logic                  out_last_reg;
    logic [COLOR_W-1:0]    out_col_reg [GLYPH_COLS];

    logic                  out_adv, s2_adv;
    logic [COLOR_W-1:0]    col [GLYPH_COLS];

    always_comb begin
        out_adv = !out_valid_reg || m_tready;
        s2_adv  = !s2_valid_reg || out_adv;
        s1_adv  = !s1.valid || s2_adv;
        s2_valid_next  = s2_adv ? s1.valid : s2_valid_reg;
        out_valid_next = out_adv ? s2_valid_reg : out_valid_reg;
        // Bit 7 of a glyph row is the leftmost column.
        for (int c = 0; c < GLYPH_COLS; c++) begin
            if (s1.pixel) begin
                col[c] = (c == 0) ? s1.fg : '0;
            end else begin
                col[c] = glyph_bits[GLYPH_COLS - 1 - c] ? s1.fg : s1.bg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            s2_prod_reg <= PROD_W'(s1.py) * PROD_W'(cfg.line_pitch);
            s2_x_reg    <= s1.x;
            s2_mask_reg <= s1.mask;
            s2_last_reg <= s1.last;
            for (int c = 0; c < GLYPH_COLS; c++) begin
                s2_col_reg[c] <= col[c];
            end
        end
        if (out_adv) begin
            out_addr_reg <= cfg.frame_base + ADDR_W'(s2_prod_reg) + ADDR_W'({s2_x_reg, 2'b00});
            out_mask_reg <= s2_mask_reg;
            out_last_reg <= s2_last_reg;
            for (int c = 0; c < GLYPH_COLS; c++) begin
                out_col_reg[c] <= s2_col_reg[c];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_col_reg[7], out_col_reg[6], out_col_reg[5], out_col_reg[4],
                       out_col_reg[3], out_col_reg[2], out_col_reg[1], out_col_reg[0],
                       out_mask_reg, out_addr_reg};

endmodule

// ----- src/glyph_pixel_writer_unit.sv -----
// Top level of the glyph pixel writer: configuration registers, font store and the
// issue and row-builder stages. Depends on gpw_pkg, gpw_ram, gpw_issue and gpw_build.
//
// The block turns drawing commands into 32-bit framebuffer writes of up to eight
// pixels. A pixel command (opcode 0) gives one beat, or none when the pixel lies off
// screen. A character command (opcode 1) gives one beat per glyph row, GLYPH_ROWS
// rows or sixteen by default, with m_tlast on the final one; the font store has a
// single read port, which delivers one glyph row per cycle while the output does not
// stall. A font load (opcode 2) gives no beat, and opcode 3 is dropped. Consecutive
// commands follow without gaps, and a new command is taken while earlier rows are
// still in the pipeline or waiting at the output. From acceptance to the first result
// beat a command passes the command register, the font store read, the line times
// pitch multiply, then the frame base addition into the output register. The font
// store holds nothing meaningful after reset: a glyph row must be loaded before a
// character using it is drawn. Configuration writes must only be made while the
// block is idle.
module glyph_pixel_writer_unit #(
    parameter int MAX_DIM     = gpw_pkg::MAX_DIM_DEF,
    parameter int GLYPH_ROWS  = gpw_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = gpw_pkg::GLYPH_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [gpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpw_pkg::ADDR_W-1:0]     cfg_wdata,
    // Command stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0: opcode, x_pos, y_pos, char_code, fg_color, bg_color,
    // font_row, font_bits, two zero bits.
    input  logic [gpw_pkg::S_TDATA_W-1:0]  s_tdata,
    // Pixel write stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: row_address, write_mask, pixel_color_0 .. pixel_color_7.
    output logic [gpw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import gpw_pkg::*;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW         = $clog2(FONT_DEPTH);

    cfg_t                  cfg_reg, cfg_next;
    row_cmd_t              s1;
    logic                  s1_adv;
    logic                  ram_wr_en, ram_rd_en;
    logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
    logic [GLYPH_COLS-1:0] ram_wr_data, ram_rd_data;

    // Register writes take the low bits of the data word.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_BASE:    cfg_next.frame_base    = cfg_wdata;
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata[DIM_W-1:0];
                CFG_LINE_PITCH:    cfg_next.line_pitch    = cfg_wdata[PITCH_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base    <= FRAME_BASE_RST;
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.line_pitch    <= LINE_PITCH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The font store: one glyph row per entry, indexed by glyph times rows plus row.
    gpw_ram #(
        .WIDTH (GLYPH_COLS),
        .DEPTH (FONT_DEPTH)
    ) u_font_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Holds the command; issues one row, pixel or font load per cycle unless stalled.
    gpw_issue #(
        .MAX_DIM     (MAX_DIM),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_issue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg         (cfg_reg),
        .s1_adv      (s1_adv),
        .s1          (s1),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    // Turns issued rows into addressed, coloured write beats behind a stallable pipeline.
    gpw_build u_build (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s1         (s1),
        .glyph_bits (ram_rd_data),
        .cfg        (cfg_reg),
        .s1_adv     (s1_adv),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- test/glyph_pixel_writer_unit_checker.sv -----
// Predictor and comparator for the glyph pixel writer.
// It watches the configuration port and both streams, and keeps its own copy of
// the registers and the font store. Depends on gpw_pkg.
module gpw_write_predictor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpw_pkg::ADDR_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gpw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gpw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    output int                             writes_pending,
    output int                             writes_seen,
    output int                             mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import gpw_pkg::*;

    localparam int MASK_LSB   = ADDR_W;
    localparam int COLOUR_LSB = ADDR_W + GLYPH_COLS;

    // Command beat as it sits in s_tdata, highest field first.
    typedef struct packed {
        logic [1:0]          pad;
        logic [7:0]          font_bits;
        logic [FROW_W-1:0]   font_row;
        logic [COLOR_W-1:0]  bg_color;
        logic [COLOR_W-1:0]  fg_color;
        logic [CODE_W-1:0]   char_code;
        logic [POS_W-1:0]    y_pos;
        logic [POS_W-1:0]    x_pos;
        logic [OPCODE_W-1:0] opcode;
    } draw_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]             row_address;
        logic [GLYPH_COLS-1:0]         write_mask;
        logic [GLYPH_COLS*COLOR_W-1:0] colours;
        logic                          last_of_run;
    } pixel_write_t;

    logic [ADDR_W-1:0]  frame_base;
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [PITCH_W-1:0] line_pitch;
    logic [7:0]         glyph_rows [GLYPH_COUNT_DEF*GLYPH_ROWS_DEF];
    pixel_write_t       queued_writes [$];

    // Register values above the largest screen act as the largest screen.
    function automatic int visible(input logic [DIM_W-1:0] v);
        return (int'(v) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] pixel_address(input logic [63:0] x,
                                                        input logic [63:0] py);
        logic [63:0] base64;
        logic [63:0] pitch64;
        logic [63:0] sum;
        base64  = 64'(frame_base);
        pitch64 = 64'(line_pitch);
        sum     = base64 + py * pitch64 + 64'd4 * x;
        return sum[ADDR_W-1:0];
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 100)
            $display("%0t ns: %s wrong on write beat %0d: got %h, expected %h",
                     $realtime, field, writes_seen, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        draw_cmd_t    cmd;
        pixel_write_t wr;
        pixel_write_t want;
        logic [63:0]  py;
        logic [7:0]   bits;
        int           w;
        int           h;
        int           r;
        int           col;
        if (!aresetn) begin
            frame_base    = FRAME_BASE_RST;
            screen_width  = SCREEN_WIDTH_RST;
            screen_height = SCREEN_HEIGHT_RST;
            line_pitch    = LINE_PITCH_RST;
            queued_writes.delete();
            writes_seen   = 0;
            mismatches    = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_BASE:    frame_base    = cfg_wdata;
                    CFG_SCREEN_WIDTH:  screen_width  = cfg_wdata[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: screen_height = cfg_wdata[DIM_W-1:0];
                    CFG_LINE_PITCH:    line_pitch    = cfg_wdata[PITCH_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                cmd = s_tdata;
                w   = visible(screen_width);
                h   = visible(screen_height);
                case (cmd.opcode)
                    OP_PIXEL: begin
                        if (int'(cmd.x_pos) < w && int'(cmd.y_pos) < h) begin
                            wr = '0;
                            wr.row_address          = pixel_address(64'(cmd.x_pos),
                                                                    64'(cmd.y_pos));
                            wr.write_mask           = 8'h01;
                            wr.colours[COLOR_W-1:0] = cmd.fg_color;
                            wr.last_of_run          = 1'b1;
                            queued_writes.push_back(wr);
                        end
                    end
                    OP_CHAR: begin
                        for (r = 0; r < GLYPH_ROWS_DEF; r++) begin
                            py   = 64'(cmd.y_pos) + 64'(r);
                            bits = glyph_rows[int'(cmd.char_code) * GLYPH_ROWS_DEF + r];
                            wr   = '0;
                            for (col = 0; col < GLYPH_COLS; col++) begin
                                // Column 0 of the glyph is bit 7 of the row.
                                if (py < 64'(h) && int'(cmd.x_pos) + col < w)
                                    wr.write_mask[col] = 1'b1;
                                wr.colours[col*COLOR_W +: COLOR_W] =
                                    bits[7-col] ? cmd.fg_color : cmd.bg_color;
                            end
                            wr.row_address = pixel_address(64'(cmd.x_pos), py);
                            wr.last_of_run = (r == GLYPH_ROWS_DEF - 1);
                            queued_writes.push_back(wr);
                        end
                    end
                    OP_LOAD: begin
                        if (int'(cmd.font_row) < GLYPH_ROWS_DEF)
                            glyph_rows[int'(cmd.char_code) * GLYPH_ROWS_DEF +
                                       int'(cmd.font_row)] = cmd.font_bits;
                    end
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (queued_writes.size() == 0) begin
                    report_mismatch("unexpected beat, row_address",
                                    64'(m_tdata[ADDR_W-1:0]), 64'd0);
                end else begin
                    want = queued_writes.pop_front();
                    if (m_tdata[ADDR_W-1:0] !== want.row_address)
                        report_mismatch("row_address", 64'(m_tdata[ADDR_W-1:0]),
                                        64'(want.row_address));
                    if (m_tdata[MASK_LSB +: GLYPH_COLS] !== want.write_mask)
                        report_mismatch("write_mask", 64'(m_tdata[MASK_LSB +: GLYPH_COLS]),
                                        64'(want.write_mask));
                    for (col = 0; col < GLYPH_COLS; col++) begin
                        if (m_tdata[COLOUR_LSB + col*COLOR_W +: COLOR_W] !==
                            want.colours[col*COLOR_W +: COLOR_W])
                            report_mismatch($sformatf("pixel_color_%0d", col),
                                            64'(m_tdata[COLOUR_LSB + col*COLOR_W +: COLOR_W]),
                                            64'(want.colours[col*COLOR_W +: COLOR_W]));
                    end
                    if (m_tlast !== want.last_of_run)
                        report_mismatch("last_of_run", 64'(m_tlast), 64'(want.last_of_run));
                end
                writes_seen++;
            end
        end
        writes_pending = queued_writes.size();
    end

endmodule

// ----- test/glyph_pixel_writer_unit_tb.sv -----
// Top level of the glyph pixel writer testbench: clock, reset, command stimulus,
// register settings, output back-pressure and the verdict.
// Depends on gpw_pkg, glyph_pixel_writer_unit and gpw_write_predictor.
module glyph_pixel_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gpw_pkg::*;

    // Opcode 3 has no name in the package; the block must drop it.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int NUM_SETTINGS    = 8;
    localparam int ITEMS_PER_PHASE = 12;
    // Quiet time after the output drains, kept for safety before a register write.
    localparam int SETTLE_CYCLES   = 10;
    localparam int CYCLE_LIMIT     = 400000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int writes_pending;
    int writes_seen;
    int mismatches;

    // Bookkeeping on the stimulus side: which font rows have been loaded, so that a
    // character is only drawn once all sixteen of its rows hold known data.
    bit glyph_row_loaded [GLYPH_COUNT_DEF*GLYPH_ROWS_DEF];
    bit glyph_drawable   [GLYPH_COUNT_DEF];
    int drawable_codes   [$];

    int cur_w;
    int cur_h;
    int burst_left  = 0;
    int cmd_count   = 0;
    int cycle_count = 0;

    glyph_pixel_writer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    gpw_write_predictor predictor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .writes_pending (writes_pending),
        .writes_seen    (writes_seen),
        .mismatches     (mismatches)
    );

    // 20 ns clock.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("glyph_pixel_writer_unit test failed");
            $finish;
        end
    end

    // The receiver stalls on its own pattern: stretches that are always ready,
    // stretches of coin-toss readiness and short hard stalls.
    initial begin : sink_pattern
        int stall_mode;
        int stall_run;
        stall_mode = 0;
        stall_run  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_run  = (stall_mode == 2) ? $urandom_range(1, 6) : $urandom_range(4, 40);
            end
            stall_run--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= 1'b0;
            endcase
        end
    end

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // Coordinates are drawn from the whole field, close to the visible edge, close to
    // zero, or from inside the screen, so that clipping is hit from both sides.
    function automatic logic [POS_W-1:0] pick_coord(input int limit);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 4095);
            1:       v = limit - 8 + int'($urandom_range(0, 9));
            2:       v = $urandom_range(0, 15);
            default: v = (limit > 0) ? $urandom_range(0, limit - 1) : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[POS_W-1:0];
    endfunction

    // Sends one command beat. The sender works in bursts: when a burst runs out, a
    // random gap (possibly none) is left before the next one starts. The task is
    // entered and left at a falling edge.
    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [CODE_W-1:0] code,
                            input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                            input logic [FROW_W-1:0] frow, input logic [7:0] fbits);
        int gap;
        int r;
        bit complete;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  <= {2'b00, fbits, frow, bg, fg, code, y, x, op};
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
        burst_left--;

        if (op == OP_LOAD) begin
            glyph_row_loaded[int'(code) * GLYPH_ROWS_DEF + int'(frow)] = 1'b1;
            complete = 1'b1;
            for (r = 0; r < GLYPH_ROWS_DEF; r++)
                if (!glyph_row_loaded[int'(code) * GLYPH_ROWS_DEF + r])
                    complete = 1'b0;
            if (complete && !glyph_drawable[code]) begin
                glyph_drawable[code] = 1'b1;
                drawable_codes.push_back(int'(code));
            end
        end
        // Opcode 3 is dropped by the block and does not count as work.
        if (op != OP_UNUSED)
            cmd_count++;
    endtask

    // Fields a command does not use still get random values.
    task automatic load_row(input logic [CODE_W-1:0] code, input logic [FROW_W-1:0] row,
                            input logic [7:0] bits);
        send_cmd(OP_LOAD, POS_W'($urandom), POS_W'($urandom), code, $urandom, $urandom,
                 row, bits);
    endtask

    task automatic draw_char(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [COLOR_W-1:0] fg,
                             input logic [COLOR_W-1:0] bg);
        send_cmd(OP_CHAR, x, y, code, fg, bg, FROW_W'($urandom), 8'($urandom));
    endtask

    task automatic draw_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [COLOR_W-1:0] fg);
        send_cmd(OP_PIXEL, x, y, CODE_W'($urandom), fg, $urandom, FROW_W'($urandom),
                 8'($urandom));
    endtask

    // A whole glyph, its rows loaded in shuffled order.
    task automatic load_glyph(input logic [CODE_W-1:0] code);
        int order [GLYPH_ROWS_DEF];
        int i;
        int j;
        int t;
        for (i = 0; i < GLYPH_ROWS_DEF; i++)
            order[i] = i;
        for (i = GLYPH_ROWS_DEF - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < GLYPH_ROWS_DEF; i++)
            load_row(code, FROW_W'(order[i]), 8'($urandom_range(0, 255)));
    endtask

    // Stops the sender until every expected write beat has come back, then lets the
    // pipeline settle, since a trailing font load or clipped pixel leaves no beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(negedge aclk);
        while (writes_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    // Only called with the block idle.
    task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h, input logic [PITCH_W-1:0] pitch);
        cfg_write(CFG_FRAME_BASE, base);
        cfg_write(CFG_SCREEN_WIDTH, ADDR_W'(w));
        cfg_write(CFG_SCREEN_HEIGHT, ADDR_W'(h));
        cfg_write(CFG_LINE_PITCH, ADDR_W'(pitch));
        cfg_wr_en <= 1'b0;
        cur_w = (int'(w) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(w);
        cur_h = (int'(h) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(h);
    endtask

    initial begin : stimulus
        int          s;
        int          r;
        int          pick;
        int          phase_start;
        bit          paused;
        logic [7:0]  bits;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cur_w = int'(SCREEN_WIDTH_RST);
        cur_h = int'(SCREEN_HEIGHT_RST);

        // Reset is held low from the start and released at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, under the reset register values (640 x 480, pitch 2560).
        // Glyph 0xFF is loaded with full, empty, single-edge and alternating rows.
        for (r = 0; r < GLYPH_ROWS_DEF; r++) begin
            case (r)
                0:       bits = 8'hFF;
                1:       bits = 8'h00;
                2:       bits = 8'h80;
                3:       bits = 8'h01;
                4:       bits = 8'hAA;
                5:       bits = 8'h55;
                default: bits = 8'($urandom_range(0, 255));
            endcase
            load_row(8'hFF, FROW_W'(r), bits);
        end
        // A lone row of glyph 0: the lowest code in a load, never drawn.
        load_row(8'h00, 4'd0, 8'hFF);
        // Character at the origin, one straddling the bottom-right corner (partial
        // columns and rows below the screen) and one entirely off screen.
        draw_char(8'hFF, 12'd0, 12'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        draw_char(8'hFF, 12'd636, 12'd470, 32'hFFFF_FFFF, 32'h0000_0000);
        draw_char(8'hFF, 12'hFFF, 12'hFFF, $urandom, $urandom);
        // Pixels on the first and last visible positions and just past each edge.
        draw_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
        draw_pixel(12'd639, 12'd479, 32'h0000_0000);
        draw_pixel(12'd640, 12'd0, $urandom);
        draw_pixel(12'd0, 12'd480, $urandom);
        draw_pixel(12'hFFF, 12'hFFF, $urandom);
        // The unused opcode with every data bit set must leave no trace.
        send_cmd(OP_UNUSED, 12'hFFF, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 4'hF, 8'hFF);

        // Random part, one phase per register setting. Setting 0 keeps the reset
        // values; the others cover the largest and smallest screens, widths and
        // heights above the maximum, an empty screen, pitches below one pixel and
        // frame bases that make the address wrap.
        for (s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                drain();
                case (s)
                    1:       apply_settings(48'hFFFF_FFFF_F000, 13'd4096, 13'd4096, 16'hFFFF);
                    2:       apply_settings(48'h0, 13'd1, 13'd1, 16'd4);
                    3:       apply_settings(rand48(), 13'h1FFF, 13'd5000, 16'd0);
                    4:       apply_settings(rand48(), 13'd0, 13'd0, 16'd3);
                    5:       apply_settings(rand48(), 13'd800, 13'd600, 16'd3200);
                    6:       apply_settings(rand48(), 13'd100, 13'd37, 16'd1);
                    default: apply_settings(48'h8000_0000_0000, 13'd4095, 13'd4095, 16'd16384);
                endcase
            end

            phase_start = cmd_count;
            paused      = 1'b0;
            while (cmd_count - phase_start < ITEMS_PER_PHASE) begin
                // Halfway through every other phase the sender holds off until the
                // output has fully drained, so the pipeline restarts from empty.
                if (s % 2 == 1 && !paused && cmd_count - phase_start >= ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    load_glyph(CODE_W'($urandom_range(0, 255)));
                else if (pick < 20)
                    load_row(CODE_W'($urandom_range(0, 255)), FROW_W'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)));
                else if (pick < 55 && drawable_codes.size() > 0)
                    draw_char(CODE_W'(drawable_codes[$urandom_range(0,
                                                    drawable_codes.size() - 1)]),
                              pick_coord(cur_w), pick_coord(cur_h), $urandom, $urandom);
                else if (pick < 90)
                    draw_pixel(pick_coord(cur_w), pick_coord(cur_h), $urandom);
                else
                    send_cmd(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), CODE_W'($urandom),
                             $urandom, $urandom, FROW_W'($urandom), 8'($urandom));
            end
        end

        // Wait for the last beats and a few quiet cycles in which nothing more may appear.
        drain();

        $display("Sent %0d commands over %0d register settings; %0d write beats checked,",
                 cmd_count, NUM_SETTINGS, writes_seen);
        $display("including clipped and wrapped addresses under random output stalls.");
        if (mismatches == 0)
            $display("glyph_pixel_writer_unit test passed");
        else
            $display("glyph_pixel_writer_unit test failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/gpw_pkg.sv
src/gpw_ram.sv
src/gpw_issue.sv
src/gpw_build.sv
src/glyph_pixel_writer_unit.sv
test/glyph_pixel_writer_unit_checker.sv
test/glyph_pixel_writer_unit_tb.sv
